@@ design/lmc_pkg.sv @@
// Shared types and constants of the lighting mode controller.
// Used by the divider and the top level; no dependencies.
`default_nettype none

package lmc_pkg;

    // Timestamp width for elapsed-time arithmetic
    localparam int TIME_BITS = 32;

    // Event codes
    localparam logic [2:0] FUNC_MODE  = 3'd0;
    localparam logic [2:0] FUNC_LED   = 3'd1;
    localparam logic [2:0] FUNC_BTN   = 3'd2;
    localparam logic [2:0] FUNC_LIGHT = 3'd3;
    localparam logic [2:0] FUNC_AUTO  = 3'd4;

    // Mode codes
    localparam logic [1:0] MODE_OFF    = 2'd0;
    localparam logic [1:0] MODE_MANUAL = 2'd1;
    localparam logic [1:0] MODE_AUTO   = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] CFG_DARK     = 3'd0;
    localparam logic [2:0] CFG_BRIGHT   = 3'd1;
    localparam logic [2:0] CFG_LVL_MAX  = 3'd2;
    localparam logic [2:0] CFG_LVL_MIN  = 3'd3;
    localparam logic [2:0] CFG_DEBOUNCE = 3'd4;
    localparam logic [2:0] CFG_REFRESH  = 3'd5;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Divider: dividend is a 7 x 8 bit product, divisor a 7 bit span
    localparam int DIV_NUM_W = 15;
    localparam int DIV_DEN_W = 7;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_APPLY,
        ST_DONE
    } t_state;

endpackage

`default_nettype wire

@@ design/lmc_in_if.sv @@
// Event input channel of the lighting mode controller: valid/ready plus event fields.
// Depends on nothing but plain logic types.
`default_nettype none

interface lmc_in_if;
    logic       valid;
    logic       ready;
    logic [2:0] func;
    logic [31:0] now_ms;
    logic [1:0] mode_req;
    logic       led_sel;
    logic       want_on;
    logic       from_auto;
    logic       button1_low;
    logic       button2_low;
    logic [6:0] light_pct;

    modport source (
        output valid, func, now_ms, mode_req, led_sel, want_on, from_auto,
               button1_low, button2_low, light_pct,
        input  ready
    );
    modport sink (
        input  valid, func, now_ms, mode_req, led_sel, want_on, from_auto,
               button1_low, button2_low, light_pct,
        output ready
    );
endinterface

`default_nettype wire

@@ design/lmc_out_if.sv @@
// Result output channel of the lighting mode controller: valid/ready plus state report.
// Depends on nothing but plain logic types.
`default_nettype none

interface lmc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] duty1;
    logic [7:0] duty2;
    logic       led1_is_on;
    logic       led2_is_on;
    logic [1:0] mode_now;
    logic [7:0] level_now;
    logic       refused;

    modport source (
        output valid, duty1, duty2, led1_is_on, led2_is_on, mode_now, level_now,
               refused,
        input  ready
    );
    modport sink (
        input  valid, duty1, duty2, led1_is_on, led2_is_on, mode_now, level_now,
               refused,
        output ready
    );
endinterface

`default_nettype wire

@@ design/lmc_div.sv @@
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on lmc_pkg for operand widths.
`default_nettype none

module lmc_div (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    input  wire                            i_start,
    input  wire [lmc_pkg::DIV_NUM_W-1:0]   i_dividend,
    input  wire [lmc_pkg::DIV_DEN_W-1:0]   i_divisor,
    output logic                           o_done,
    output logic [lmc_pkg::DIV_NUM_W-1:0]  o_quotient
);

    logic                           r_busy, n_busy;
    logic                           r_done, n_done;
    logic [lmc_pkg::DIV_CNT_W-1:0]  r_cnt, n_cnt;
    logic [lmc_pkg::DIV_NUM_W-1:0]  r_quo, n_quo;
    logic [lmc_pkg::DIV_DEN_W-1:0]  r_rem, n_rem;
    logic [lmc_pkg::DIV_DEN_W-1:0]  r_den, n_den;

    logic [lmc_pkg::DIV_DEN_W:0]    rem_sh;
    logic                           ge;

    always_comb begin
        rem_sh = {r_rem, r_quo[lmc_pkg::DIV_NUM_W-1]};
        ge     = rem_sh >= {1'b0, r_den};
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = lmc_pkg::DIV_CNT_W'(lmc_pkg::DIV_NUM_W - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_den  = i_divisor;
        end else if (r_busy) begin
            // shift in the next dividend bit, subtract when it fits
            n_rem = ge ? lmc_pkg::DIV_DEN_W'(rem_sh - {1'b0, r_den})
                       : lmc_pkg::DIV_DEN_W'(rem_sh);
            n_quo = {r_quo[lmc_pkg::DIV_NUM_W-2:0], ge};
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - lmc_pkg::DIV_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire

@@ design/lighting_mode_controller_top.sv @@
// Lighting mode controller top level: event sequencer, state and configuration registers.
// Depends on lmc_pkg, lmc_in_if, lmc_out_if and lmc_div.
//
// Usage:
//   Events arrive on i_in (valid/ready); one transfer is one event. For every
//   event exactly one result, the controller state after the event, leaves on
//   o_out (valid/ready). Configuration registers are written through
//   i_cfg_we / i_cfg_idx / i_cfg_data; the user must write them only while no
//   event is in flight, as the block does not enforce this.
//   Sequencing: i_in.ready is high only while the sequencer is idle. Most events
//   pass through EVAL and DONE; an automatic update that runs without the
//   linear map also passes through APPLY. An update that maps the light inside
//   the threshold window passes through MUL, DIV and APPLY: in DIV the
//   divider produces one quotient bit per cycle over 15 bits.
//   Stalls: the result sits in an output register; the next event is taken
//   while it waits, and that event holds in its final step until the
//   previous result has transferred.
//   Reset (synchronous, active low): MANUAL mode, both LEDs off, duties 0,
//   level 255, configuration at its defaults, no result pending.
`default_nettype none

module lighting_mode_controller_top (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    lmc_in_if.sink                           i_in,
    lmc_out_if.source                        o_out,
    input  wire                              i_cfg_we,
    input  wire [lmc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  wire [lmc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int TB = lmc_pkg::TIME_BITS;

    // configuration
    logic [6:0]  r_cfg_dark, r_cfg_bright;
    logic [7:0]  r_cfg_lmax, r_cfg_lmin;
    logic [15:0] r_cfg_debounce, r_cfg_refresh;

    // controller state
    lmc_pkg::t_state r_state, n_state;
    logic [1:0]    r_mode, n_mode;
    logic          r_led1, n_led1, r_led2, n_led2;
    logic [7:0]    r_level, n_level;
    logic [6:0]    r_light, n_light;
    logic [TB-1:0] r_last_ref, n_last_ref;
    logic [TB-1:0] r_last_p1, n_last_p1, r_last_p2, n_last_p2;
    logic [7:0]    r_duty1, n_duty1, r_duty2, n_duty2;
    logic          r_refused, n_refused;
    logic [7:0]    r_target, n_target;
    logic          r_neg, n_neg;

    // captured event
    logic [2:0]    r_func, n_func;
    logic [TB-1:0] r_now, n_now;
    logic [1:0]    r_mode_req, n_mode_req;
    logic          r_led_sel, n_led_sel, r_want_on, n_want_on, r_from_auto, n_from_auto;
    logic          r_b1, n_b1, r_b2, n_b2;
    logic [6:0]    r_light_pct, n_light_pct;

    // output register
    logic          r_out_valid, n_out_valid;
    logic [7:0]    r_o_duty1, n_o_duty1, r_o_duty2, n_o_duty2, r_o_level, n_o_level;
    logic          r_o_led1, n_o_led1, r_o_led2, n_o_led2, r_o_refused, n_o_refused;
    logic [1:0]    r_o_mode, n_o_mode;

    // divider hookup
    logic                           div_start;
    logic                           div_done;
    logic [lmc_pkg::DIV_NUM_W-1:0]  div_quo;
    logic [lmc_pkg::DIV_NUM_W-1:0]  mul_prod;
    logic [lmc_pkg::DIV_DEN_W-1:0]  div_span;

    logic [TB-1:0] el_ref, el_p1, el_p2;
    logic          refresh_due;
    logic [7:0]    lvl_mag;
    logic [6:0]    light_off;
    logic [7:0]    q8;

    lmc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (mul_prod),
        .i_divisor  (div_span),
        .o_done     (div_done),
        .o_quotient (div_quo)
    );

    assign el_ref      = r_now - r_last_ref;
    assign el_p1       = r_now - r_last_p1;
    assign el_p2       = r_now - r_last_p2;
    assign refresh_due = el_ref >= TB'(r_cfg_refresh);
    assign lvl_mag     = r_neg ? (r_cfg_lmax - r_cfg_lmin) : (r_cfg_lmin - r_cfg_lmax);
    assign light_off   = r_light - r_cfg_dark;
    assign mul_prod    = lmc_pkg::DIV_NUM_W'(light_off) * lmc_pkg::DIV_NUM_W'(lvl_mag);
    assign div_span    = r_cfg_bright - r_cfg_dark;
    assign div_start   = (r_state == lmc_pkg::ST_MUL);
    assign q8          = div_quo[7:0];

    // configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dark     <= 7'd20;
            r_cfg_bright   <= 7'd80;
            r_cfg_lmax     <= 8'd255;
            r_cfg_lmin     <= 8'd10;
            r_cfg_debounce <= 16'd200;
            r_cfg_refresh  <= 16'd100;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                lmc_pkg::CFG_DARK:     r_cfg_dark     <= i_cfg_data[6:0];
                lmc_pkg::CFG_BRIGHT:   r_cfg_bright   <= i_cfg_data[6:0];
                lmc_pkg::CFG_LVL_MAX:  r_cfg_lmax     <= i_cfg_data[7:0];
                lmc_pkg::CFG_LVL_MIN:  r_cfg_lmin     <= i_cfg_data[7:0];
                lmc_pkg::CFG_DEBOUNCE: r_cfg_debounce <= i_cfg_data;
                lmc_pkg::CFG_REFRESH:  r_cfg_refresh  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        logic start_map;
        start_map   = 1'b0;
        n_state     = r_state;
        n_mode      = r_mode;
        n_led1      = r_led1;
        n_led2      = r_led2;
        n_level     = r_level;
        n_light     = r_light;
        n_last_ref  = r_last_ref;
        n_last_p1   = r_last_p1;
        n_last_p2   = r_last_p2;
        n_duty1     = r_duty1;
        n_duty2     = r_duty2;
        n_refused   = r_refused;
        n_target    = r_target;
        n_neg       = r_neg;
        n_func      = r_func;
        n_now       = r_now;
        n_mode_req  = r_mode_req;
        n_led_sel   = r_led_sel;
        n_want_on   = r_want_on;
        n_from_auto = r_from_auto;
        n_b1        = r_b1;
        n_b2        = r_b2;
        n_light_pct = r_light_pct;
        n_out_valid = r_out_valid && !o_out.ready;
        n_o_duty1   = r_o_duty1;
        n_o_duty2   = r_o_duty2;
        n_o_level   = r_o_level;
        n_o_led1    = r_o_led1;
        n_o_led2    = r_o_led2;
        n_o_refused = r_o_refused;
        n_o_mode    = r_o_mode;

        unique case (r_state)
            lmc_pkg::ST_IDLE: begin
                if (i_in.valid) begin
                    n_func      = i_in.func;
                    n_now       = TB'(i_in.now_ms);
                    n_mode_req  = i_in.mode_req;
                    n_led_sel   = i_in.led_sel;
                    n_want_on   = i_in.want_on;
                    n_from_auto = i_in.from_auto;
                    n_b1        = i_in.button1_low;
                    n_b2        = i_in.button2_low;
                    n_light_pct = i_in.light_pct;
                    n_state     = lmc_pkg::ST_EVAL;
                end
            end
            lmc_pkg::ST_EVAL: begin
                n_refused = 1'b0;
                n_state   = lmc_pkg::ST_DONE;
                unique case (r_func)
                    lmc_pkg::FUNC_MODE: begin
                        unique case (r_mode_req)
                            lmc_pkg::MODE_OFF: begin
                                n_mode  = lmc_pkg::MODE_OFF;
                                n_led1  = 1'b0;
                                n_led2  = 1'b0;
                                n_duty1 = '0;
                                n_duty2 = '0;
                            end
                            lmc_pkg::MODE_MANUAL: begin
                                n_mode  = lmc_pkg::MODE_MANUAL;
                                n_level = r_cfg_lmax;
                                n_duty1 = r_led1 ? r_cfg_lmax : 8'd0;
                                n_duty2 = r_led2 ? r_cfg_lmax : 8'd0;
                            end
                            lmc_pkg::MODE_AUTO: begin
                                n_mode    = lmc_pkg::MODE_AUTO;
                                n_led1    = 1'b1;
                                n_led2    = 1'b1;
                                start_map = refresh_due;
                            end
                            default: ;
                        endcase
                    end
                    lmc_pkg::FUNC_LED: begin
                        if (r_mode == lmc_pkg::MODE_OFF ||
                            (r_mode == lmc_pkg::MODE_AUTO && !r_from_auto)) begin
                            n_refused = 1'b1;
                        end else if (r_led_sel) begin
                            n_led2  = r_want_on;
                            n_duty2 = r_want_on ? r_level : 8'd0;
                        end else begin
                            n_led1  = r_want_on;
                            n_duty1 = r_want_on ? r_level : 8'd0;
                        end
                    end
                    lmc_pkg::FUNC_BTN: begin
                        if (r_mode == lmc_pkg::MODE_MANUAL) begin
                            // toggle each pressed LED once its debounce window has passed
                            if (r_b1 && el_p1 > TB'(r_cfg_debounce)) begin
                                n_last_p1 = r_now;
                                n_led1    = !r_led1;
                                n_duty1   = r_led1 ? 8'd0 : r_level;
                            end
                            if (r_b2 && el_p2 > TB'(r_cfg_debounce)) begin
                                n_last_p2 = r_now;
                                n_led2    = !r_led2;
                                n_duty2   = r_led2 ? 8'd0 : r_level;
                            end
                        end
                    end
                    lmc_pkg::FUNC_LIGHT: begin
                        n_light = r_light_pct;
                    end
                    lmc_pkg::FUNC_AUTO: begin
                        start_map = (r_mode == lmc_pkg::MODE_AUTO) && refresh_due;
                    end
                    default: ;
                endcase
                if (start_map) begin
                    n_last_ref = r_now;
                    n_neg      = r_cfg_lmin < r_cfg_lmax;
                    if (r_light < r_cfg_dark) begin
                        n_target = r_cfg_lmax;
                        n_state  = lmc_pkg::ST_APPLY;
                    end else if (r_light > r_cfg_bright) begin
                        n_target = r_cfg_lmin;
                        n_state  = lmc_pkg::ST_APPLY;
                    end else if (r_cfg_bright == r_cfg_dark) begin
                        n_target = r_cfg_lmax;
                        n_state  = lmc_pkg::ST_APPLY;
                    end else begin
                        n_state = lmc_pkg::ST_MUL;
                    end
                end
            end
            lmc_pkg::ST_MUL: begin
                // divider loads the product this cycle
                n_state = lmc_pkg::ST_DIV;
            end
            lmc_pkg::ST_DIV: begin
                if (div_done) begin
                    n_target = r_neg ? (r_cfg_lmax - q8) : (r_cfg_lmax + q8);
                    n_state  = lmc_pkg::ST_APPLY;
                end
            end
            lmc_pkg::ST_APPLY: begin
                if (r_target != r_level) begin
                    n_level = r_target;
                    n_led1  = 1'b1;
                    n_led2  = 1'b1;
                    n_duty1 = r_target;
                    n_duty2 = r_target;
                end
                n_state = lmc_pkg::ST_DONE;
            end
            lmc_pkg::ST_DONE: begin
                // hold until the output register is free
                if (!r_out_valid || o_out.ready) begin
                    n_out_valid = 1'b1;
                    n_o_duty1   = r_duty1;
                    n_o_duty2   = r_duty2;
                    n_o_led1    = r_led1;
                    n_o_led2    = r_led2;
                    n_o_mode    = r_mode;
                    n_o_level   = r_level;
                    n_o_refused = r_refused;
                    n_state     = lmc_pkg::ST_IDLE;
                end
            end
            default: n_state = lmc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= lmc_pkg::ST_IDLE;
            r_mode      <= lmc_pkg::MODE_MANUAL;
            r_led1      <= 1'b0;
            r_led2      <= 1'b0;
            r_level     <= 8'd255;
            r_light     <= '0;
            r_last_ref  <= '0;
            r_last_p1   <= '0;
            r_last_p2   <= '0;
            r_duty1     <= '0;
            r_duty2     <= '0;
            r_refused   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mode      <= n_mode;
            r_led1      <= n_led1;
            r_led2      <= n_led2;
            r_level     <= n_level;
            r_light     <= n_light;
            r_last_ref  <= n_last_ref;
            r_last_p1   <= n_last_p1;
            r_last_p2   <= n_last_p2;
            r_duty1     <= n_duty1;
            r_duty2     <= n_duty2;
            r_refused   <= n_refused;
            r_out_valid <= n_out_valid;
        end
        r_target    <= n_target;
        r_neg       <= n_neg;
        r_func      <= n_func;
        r_now       <= n_now;
        r_mode_req  <= n_mode_req;
        r_led_sel   <= n_led_sel;
        r_want_on   <= n_want_on;
        r_from_auto <= n_from_auto;
        r_b1        <= n_b1;
        r_b2        <= n_b2;
        r_light_pct <= n_light_pct;
        r_o_duty1   <= n_o_duty1;
        r_o_duty2   <= n_o_duty2;
        r_o_level   <= n_o_level;
        r_o_led1    <= n_o_led1;
        r_o_led2    <= n_o_led2;
        r_o_refused <= n_o_refused;
        r_o_mode    <= n_o_mode;
    end

    assign i_in.ready       = (r_state == lmc_pkg::ST_IDLE);
    assign o_out.valid      = r_out_valid;
    assign o_out.duty1      = r_o_duty1;
    assign o_out.duty2      = r_o_duty2;
    assign o_out.led1_is_on = r_o_led1;
    assign o_out.led2_is_on = r_o_led2;
    assign o_out.mode_now   = r_o_mode;
    assign o_out.level_now  = r_o_level;
    assign o_out.refused    = r_o_refused;

endmodule

`default_nettype wire
